// File: design/touch_sample_fifo_calibrate_unit_defines.svh
// assertion macros for the touch sample ring and calibration block
`ifndef TOUCH_SAMPLE_FIFO_CALIBRATE_UNIT_DEFINES_SVH
`define TOUCH_SAMPLE_FIFO_CALIBRATE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TSFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TSFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tsfc_pkg.sv
// shared types and constants for the touch sample ring and calibration block
package tsfc_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int RAW_W      = 8;
  localparam int TIME_W     = 16;
  localparam int PROD_W     = CFG_W + RAW_W + 1;

  localparam logic signed [CFG_W-1:0] X_SCALE_RST  = -16'sd439;
  localparam logic signed [CFG_W-1:0] X_OFFSET_RST = 16'sd415;
  localparam logic signed [CFG_W-1:0] Y_SCALE_RST  = -16'sd283;
  localparam logic signed [CFG_W-1:0] Y_OFFSET_RST = 16'sd257;

  localparam logic [6:0] PRESS_DOWN = 7'h7f;
  localparam logic [6:0] PRESS_UP   = 7'h00;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // touch state codes
  localparam logic [1:0] TOUCH_NONE = 2'd0;
  localparam logic [1:0] TOUCH_UP   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 2'd3;

  typedef enum logic [2:0] {
    OUT_STORED     = 3'd0,
    OUT_IGNORED    = 3'd1,
    OUT_DROP_FULL  = 3'd2,
    OUT_READ_OK    = 3'd3,
    OUT_READ_EMPTY = 3'd4
  } outcome_t;

  typedef struct packed {
    logic              pen;
    logic [RAW_W-1:0]  x;
    logic [RAW_W-1:0]  y;
    logic [TIME_W-1:0] t;
  } ring_rec_t;

  typedef struct packed {
    logic     valid;
    outcome_t outcome;
    logic     has_more;
  } ring_ctl_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] x_scale;
    logic signed [CFG_W-1:0] x_offset;
    logic signed [CFG_W-1:0] y_scale;
    logic signed [CFG_W-1:0] y_offset;
  } cal_cfg_t;

endpackage

// File: design/tsfc_ring.sv
// sample ring: pointers, push/pop decision and record memory with registered read
module tsfc_ring import tsfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                take,
  input  logic                req_type,
  input  logic [31:0]         status_word,
  input  logic [TIME_W-1:0]   timestamp,
  output ring_ctl_t           ctl,
  output ring_rec_t           rec
);

  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] read_ptr;
  logic [PTR_W-1:0] write_ptr_next;
  logic [PTR_W-1:0] read_ptr_next;
  logic [PTR_W-1:0] wp_adv;
  logic [PTR_W-1:0] rp_adv;
  logic             full;
  logic             empty;
  logic             push;
  logic             pop;
  logic [1:0]       touch;
  outcome_t         outcome_c;
  ring_rec_t        rec_in;
  ring_rec_t        mem [RING_DEPTH];

  // pointer wrap at the ring depth
  assign wp_adv = (write_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : write_ptr + PTR_W'(1);
  assign rp_adv = (read_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : read_ptr + PTR_W'(1);
  assign full   = (wp_adv == read_ptr);
  assign empty  = (write_ptr == read_ptr);
  assign touch  = status_word[21:20];

  assign rec_in.pen = (touch != TOUCH_UP);
  assign rec_in.x   = status_word[9:2];
  assign rec_in.y   = status_word[19:12];
  assign rec_in.t   = timestamp;

  // decide what the item does to the ring
  always_comb begin
    push      = 1'b0;
    pop       = 1'b0;
    outcome_c = OUT_STORED;
    if (req_type == REQ_SAMPLE) begin
      if (full) begin
        outcome_c = OUT_DROP_FULL;
      end else if (touch == TOUCH_NONE) begin
        outcome_c = OUT_IGNORED;
      end else begin
        outcome_c = OUT_STORED;
        push      = take;
      end
    end else begin
      if (empty) begin
        outcome_c = OUT_READ_EMPTY;
      end else begin
        outcome_c = OUT_READ_OK;
        pop       = take;
      end
    end
    write_ptr_next = push ? wp_adv : write_ptr;
    read_ptr_next  = pop ? rp_adv : read_ptr;
  end

  // pointers and stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
      ctl       <= '0;
    end else begin
      write_ptr <= write_ptr_next;
      read_ptr  <= read_ptr_next;
      if (en) begin
        ctl.valid    <= take;
        ctl.outcome  <= outcome_c;
        ctl.has_more <= (write_ptr_next != read_ptr_next);
      end
    end
  end

  // record memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (push) begin
      mem[write_ptr] <= rec_in;
    end
    if (pop) begin
      rec <= mem[read_ptr];
    end
  end

endmodule

// File: design/tsfc_cal.sv
// calibration: multiply stage, then shift, offset and output register
module tsfc_cal import tsfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cal_cfg_t            cfg,
  input  ring_ctl_t           ctl_in,
  input  ring_rec_t           rec_in,
  output ring_ctl_t           ctl_out,
  output logic [6:0]          pressure,
  output logic [CFG_W-1:0]    x_pos,
  output logic [CFG_W-1:0]    y_pos,
  output logic [TIME_W-1:0]   sample_time
);

  ring_ctl_t                ctl_mul;
  logic signed [PROD_W-1:0] x_prod;
  logic signed [PROD_W-1:0] y_prod;
  logic                     pen_mul;
  logic [TIME_W-1:0]        t_mul;
  logic signed [PROD_W-1:0] x_shr;
  logic signed [PROD_W-1:0] y_shr;
  logic [CFG_W-1:0]         x_sum;
  logic [CFG_W-1:0]         y_sum;
  logic                     rd_ok;

  // scale times raw value
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mul <= '0;
    end else if (en) begin
      ctl_mul <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_prod  <= PROD_W'(cfg.x_scale) * PROD_W'($signed({1'b0, rec_in.x}));
      y_prod  <= PROD_W'(cfg.y_scale) * PROD_W'($signed({1'b0, rec_in.y}));
      pen_mul <= rec_in.pen;
      t_mul   <= rec_in.t;
    end
  end

  // floor shift by eight, add offset, wrap to 16 bits
  assign x_shr = x_prod >>> 8;
  assign y_shr = y_prod >>> 8;
  assign x_sum = x_shr[CFG_W-1:0] + cfg.x_offset;
  assign y_sum = y_shr[CFG_W-1:0] + cfg.y_offset;
  assign rd_ok = (ctl_mul.outcome == OUT_READ_OK);

  // output register, data fields zero unless a record was read
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pressure    <= (rd_ok && pen_mul) ? PRESS_DOWN : PRESS_UP;
      x_pos       <= rd_ok ? x_sum : '0;
      y_pos       <= rd_ok ? y_sum : '0;
      sample_time <= rd_ok ? t_mul : '0;
    end
  end

endmodule

// File: design/touch_sample_fifo_calibrate_unit.sv
// Touch sample ring with affine X/Y calibration on read.
// Input channel (in_valid/in_stall): each item is either a controller sample
//   event (req_type 0) that may push one record, or a read request (req_type 1)
//   that pops the oldest record. The ring holds up to 255 records.
// Output channel (out_valid/out_stall): exactly one result item per input item,
//   in order, carrying outcome, pressure, calibrated positions, sample time and
//   whether records remain.
// Config port: cfg_we writes cfg_data into register cfg_index
//   (x_scale, x_offset, y_scale, y_offset); write only while the block is idle.
// Stages: ring decision and memory read, the scale multiply, then shift/offset
//   into the output register. One item per cycle while no result is stalled;
//   the ring memory has one write and one read port, one access per item.
// A stall on the output holds every stage, and in_stall rises in that cycle
//   while the output register holds a result.
// Reset empties the ring (pointers to zero), clears all valid flags and loads
//   the default calibration; record memory contents are not cleared.
module touch_sample_fifo_calibrate_unit import tsfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [31:0]          status_word,
  input  logic [TIME_W-1:0]    timestamp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           outcome,
  output logic [6:0]           pressure,
  output logic [CFG_W-1:0]     x_pos,
  output logic [CFG_W-1:0]     y_pos,
  output logic [TIME_W-1:0]    sample_time,
  output logic                 has_more,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "touch_sample_fifo_calibrate_unit_defines.svh"

  cal_cfg_t  cfg;
  ring_ctl_t ring_ctl;
  ring_rec_t ring_rec;
  ring_ctl_t res_ctl;
  logic      en;
  logic      take;

  // whole pipe moves unless a held result is stalled
  assign en       = !res_ctl.valid || !out_stall;
  assign in_stall = !en;
  assign take     = in_valid && en;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_scale  <= X_SCALE_RST;
      cfg.x_offset <= X_OFFSET_RST;
      cfg.y_scale  <= Y_SCALE_RST;
      cfg.y_offset <= Y_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_SCALE:  cfg.x_scale  <= cfg_data;
        REG_X_OFFSET: cfg.x_offset <= cfg_data;
        REG_Y_SCALE:  cfg.y_scale  <= cfg_data;
        REG_Y_OFFSET: cfg.y_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  tsfc_ring u_ring (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .take        (take),
    .req_type    (req_type),
    .status_word (status_word),
    .timestamp   (timestamp),
    .ctl         (ring_ctl),
    .rec         (ring_rec)
  );

  tsfc_cal u_cal (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cfg         (cfg),
    .ctl_in      (ring_ctl),
    .rec_in      (ring_rec),
    .ctl_out     (res_ctl),
    .pressure    (pressure),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .sample_time (sample_time)
  );

  // result fields
  assign out_valid = res_ctl.valid;
  assign outcome   = res_ctl.outcome;
  assign has_more  = res_ctl.has_more;

  // checks
  `TSFC_ASSERT_NOW(a_store_leaves_data, out_valid && (outcome == OUT_STORED || outcome == OUT_DROP_FULL), has_more, "store or full drop reported an empty ring")
  `TSFC_ASSERT_NOW(a_empty_read_empty, out_valid && outcome == OUT_READ_EMPTY, !has_more, "empty read reported remaining records")
  `TSFC_ASSERT_NOW(a_fields_zero, out_valid && outcome != OUT_READ_OK, pressure == '0 && x_pos == '0 && y_pos == '0 && sample_time == '0, "data fields not zero outside a read")
  `TSFC_ASSERT_NEXT(a_stall_holds_pipe, out_valid && out_stall, out_valid && $stable(outcome) && $stable(x_pos), "stalled result changed")

endmodule
